>>> hdl/csb_pkg.sv
// Shared constants, types and codes of the sparse column builder.
package csb_pkg;

   localparam int unsigned MAX_ENTRIES = 16384;
   localparam int unsigned MAX_COLS    = 4096;
   localparam int unsigned MAX_ROWS    = 65536;

   localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);
   localparam int unsigned CNT_W  = ADDR_W + 1;
   localparam int unsigned ROW_W  = 16;
   localparam int unsigned COL_W  = 12;
   localparam int unsigned VAL_W  = 47;

   // action codes
   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_FETCH = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_ENTRY   = 2'd0;
   localparam logic [1:0] KIND_COL_END = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   // register indexes
   localparam logic [1:0] REG_NUM_ROWS    = 2'd0;
   localparam logic [1:0] REG_NUM_COLS    = 2'd1;
   localparam logic [1:0] REG_USE_COUNTS  = 2'd2;
   localparam logic [1:0] REG_LIST_FORMAT = 2'd3;

   // stored entry; count kept with its sign bit inverted so that the whole
   // word orders as column, row, signed count under an unsigned compare
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [31:0]      cnt_key;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
   } sort_ctl_type;

   typedef struct packed {
      logic done;
   } sort_stat_type;

endpackage

>>> hdl/csb_if.sv
// Request and result channel interfaces of the sparse column builder.
interface csb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] feature_code;
   logic [31:0] barcode_code;
   logic [31:0] count;
   modport source (output valid, action, feature_code, barcode_code, count, input ready);
   modport sink   (input valid, action, feature_code, barcode_code, count, output ready);
endinterface

interface csb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [11:0] column_index;
   logic [15:0] row_index;
   logic [46:0] entry_value;
   logic [14:0] column_end_pointer;
   logic        overflow;
   logic        store_overrun;
   modport source (output valid, result_kind, column_index, row_index, entry_value,
                   column_end_pointer, overflow, store_overrun, input ready);
   modport sink   (input valid, result_kind, column_index, row_index, entry_value,
                   column_end_pointer, overflow, store_overrun, output ready);
endinterface

>>> hdl/csb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module csb_ram #(
   parameter int unsigned ADDR_BITS = 14,
   parameter int unsigned DATA_BITS = 60
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);
   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/csb_sorter.sv
// Heap sort sequencer working in place on the entry RAM.
module csb_sorter (
   input  logic                   clock,
   input  logic                   reset,
   input  csb_pkg::sort_ctl_type  ctl,
   output csb_pkg::sort_stat_type stat,
   output csb_pkg::ram_req_type   ram_req,
   input  csb_pkg::entry_type     rd_data
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_BRD  = 4'd1;
   localparam logic [3:0] ST_BVAL = 4'd2;
   localparam logic [3:0] ST_SRD1 = 4'd3;
   localparam logic [3:0] ST_SRD2 = 4'd4;
   localparam logic [3:0] ST_SCMP = 4'd5;
   localparam logic [3:0] ST_NEXT = 4'd6;
   localparam logic [3:0] ST_XR0  = 4'd7;
   localparam logic [3:0] ST_XRI  = 4'd8;
   localparam logic [3:0] ST_XWR  = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   logic [3:0]                  st_ff, st_in;
   logic                        extract_ff, extract_in;
   logic [csb_pkg::CNT_W-1:0]   n_ff, n_in;
   logic [csb_pkg::CNT_W-1:0]   i_ff, i_in;
   logic [csb_pkg::CNT_W-1:0]   lim_ff, lim_in;
   logic [csb_pkg::ADDR_W-1:0]  r_ff, r_in;
   csb_pkg::entry_type          val_ff, val_in;
   csb_pkg::entry_type          a_ff, a_in;
   csb_pkg::entry_type          top_ff, top_in;

   logic [csb_pkg::CNT_W-1:0]   child;
   logic [csb_pkg::CNT_W-1:0]   child2;
   logic                        has2;
   logic                        take2;
   csb_pkg::entry_type          pick;
   logic [csb_pkg::CNT_W-1:0]   pick_idx;

   // left child, right child and the larger of the two
   assign child    = {r_ff, 1'b1};
   assign child2   = child + csb_pkg::CNT_W'(1);
   assign has2     = child2 < lim_ff;
   assign take2    = has2 && (a_ff < rd_data);
   assign pick     = take2 ? rd_data : a_ff;
   assign pick_idx = take2 ? child2 : child;

   // sequencer
   always_comb begin
      st_in      = st_ff;
      extract_in = extract_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      lim_in     = lim_ff;
      r_in       = r_ff;
      val_in     = val_ff;
      a_in       = a_ff;
      top_in     = top_ff;
      ram_req    = '0;
      stat.done  = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               n_in       = ctl.count;
               i_in       = ctl.count >> 1;
               extract_in = 1'b0;
               st_in      = (ctl.count < csb_pkg::CNT_W'(2)) ? ST_DONE : ST_BRD;
            end
         end
         ST_BRD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = csb_pkg::ADDR_W'(i_ff - csb_pkg::CNT_W'(1));
            r_in            = csb_pkg::ADDR_W'(i_ff - csb_pkg::CNT_W'(1));
            lim_in          = n_ff;
            st_in           = ST_BVAL;
         end
         ST_BVAL: begin
            val_in = rd_data;
            st_in  = ST_SRD1;
         end
         ST_SRD1: begin
            if (child >= lim_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = r_ff;
               ram_req.wr_data = val_ff;
               st_in           = ST_NEXT;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = csb_pkg::ADDR_W'(child);
               st_in           = ST_SRD2;
            end
         end
         ST_SRD2: begin
            a_in            = rd_data;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = csb_pkg::ADDR_W'(child2);
            st_in           = ST_SCMP;
         end
         ST_SCMP: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = r_ff;
            if (val_ff < pick) begin
               ram_req.wr_data = pick;
               r_in            = csb_pkg::ADDR_W'(pick_idx);
               st_in           = ST_SRD1;
            end else begin
               ram_req.wr_data = val_ff;
               st_in           = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (i_ff == csb_pkg::CNT_W'(1)) begin
               if (extract_ff) begin
                  st_in = ST_DONE;
               end else begin
                  extract_in = 1'b1;
                  i_in       = n_ff - csb_pkg::CNT_W'(1);
                  st_in      = ST_XR0;
               end
            end else begin
               i_in  = i_ff - csb_pkg::CNT_W'(1);
               st_in = extract_ff ? ST_XR0 : ST_BRD;
            end
         end
         ST_XR0: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = '0;
            st_in           = ST_XRI;
         end
         ST_XRI: begin
            top_in          = rd_data;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = csb_pkg::ADDR_W'(i_ff);
            st_in           = ST_XWR;
         end
         ST_XWR: begin
            val_in          = rd_data;
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = csb_pkg::ADDR_W'(i_ff);
            ram_req.wr_data = top_ff;
            r_in            = '0;
            lim_in          = i_ff;
            st_in           = ST_SRD1;
         end
         ST_DONE: begin
            stat.done = 1'b1;
            st_in     = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         extract_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         extract_ff <= extract_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      i_ff   <= i_in;
      lim_ff <= lim_in;
      r_ff   <= r_in;
      val_ff <= val_in;
      a_ff   <= a_in;
      top_ff <= top_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_SRD1) |-> (lim_ff <= n_ff))
      else $error("sift limit beyond heap size");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_SCMP) |-> ($past(st_ff) == ST_SRD2))
      else $error("compare without both child reads");
   assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> (st_ff == ST_IDLE))
      else $error("sort started while busy");
endmodule

>>> hdl/coo_to_csc_sparse_builder_core.sv
// Top level of the sparse column builder: load, sort control and column emission.
//
// An add is accepted while idle and writes one entry to the store when it
// is in range and the store is still loading and not full; an add to a full
// store sets the overrun flag instead. The first fetch after loading runs
// an in-place heap sort over the n stored entries in the entry RAM, each
// sift level reading the children and writing one entry back, before its
// result appears. Each fetch after that walks the sorted store through the
// one RAM read port, folding every stored duplicate of the emitted entry
// into its value. A result waits in the output register while the next add
// is accepted.
module coo_to_csc_sparse_builder_core (
   input  logic               clock,
   input  logic               reset,
   csb_req_if.sink            req_chan,
   csb_rsp_if.source          rsp_chan,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_write_data
);
   localparam logic [2:0] T_IDLE = 3'd0;
   localparam logic [2:0] T_SORT = 3'd1;
   localparam logic [2:0] T_EMIT = 3'd2;
   localparam logic [2:0] T_DAT  = 3'd3;
   localparam logic [2:0] T_OUT  = 3'd4;

   localparam logic [1:0] PH_LOAD = 2'd0;
   localparam logic [1:0] PH_EMIT = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   localparam logic [16:0] ROWS_CAP = 17'(csb_pkg::MAX_ROWS);
   localparam logic [12:0] COLS_CAP = 13'(csb_pkg::MAX_COLS);
   localparam logic signed [csb_pkg::VAL_W-1:0] SAT_HI = 47'sh0000_7FFF_FFFF;
   localparam logic signed [csb_pkg::VAL_W-1:0] SAT_LO = -47'sh0000_8000_0000;

   // configuration
   logic [16:0] num_rows_ff;
   logic [12:0] num_cols_ff;
   logic        use_counts_ff;
   logic        list_format_ff;

   // control state
   logic [2:0]                state_ff, state_in;
   logic [1:0]                phase_ff, phase_in;
   logic [csb_pkg::CNT_W-1:0] loaded_ff, loaded_in;
   logic [12:0]               emit_col_ff, emit_col_in;
   logic [csb_pkg::CNT_W-1:0] pos_ff, pos_in;
   logic [csb_pkg::CNT_W-1:0] nnz_ff, nnz_in;
   logic                      overrun_ff, overrun_in;
   logic                      first_ff, first_in;

   // result being built
   logic [csb_pkg::ROW_W-1:0]         row_ff, row_in;
   logic signed [csb_pkg::VAL_W-1:0]  sum_ff, sum_in;
   logic                              sat_ff, sat_in;
   logic [1:0]                        kind_ff, kind_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_kind_ff;
   logic [11:0]               rsp_col_ff;
   logic [15:0]               rsp_row_ff;
   logic [46:0]               rsp_val_ff;
   logic [14:0]               rsp_ptr_ff;
   logic                      rsp_ovf_ff;
   logic                      rsp_ovr_ff;
   logic                      rsp_load;

   // memory and sorter
   csb_pkg::ram_req_type   ram_req;
   csb_pkg::ram_req_type   top_req;
   csb_pkg::ram_req_type   sort_req;
   csb_pkg::entry_type     rd_data;
   csb_pkg::sort_ctl_type  sort_ctl;
   csb_pkg::sort_stat_type sort_stat;

   logic [16:0] eff_rows;
   logic [12:0] eff_cols;
   logic        accept;
   logic        add_ok;
   logic signed [csb_pkg::VAL_W-1:0] addend;
   logic signed [csb_pkg::VAL_W-1:0] sum_next;
   logic        clamp;
   logic        same;
   logic [csb_pkg::CNT_W-1:0] pos_inc;

   assign eff_rows = (num_rows_ff > ROWS_CAP) ? ROWS_CAP : num_rows_ff;
   assign eff_cols = (num_cols_ff > COLS_CAP) ? COLS_CAP : num_cols_ff;

   assign req_chan.ready = (state_ff == T_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // range check of an add
   assign add_ok = !req_chan.feature_code[31] && (req_chan.feature_code != 32'd0) &&
                   !req_chan.barcode_code[31] && (req_chan.barcode_code != 32'd0) &&
                   (req_chan.feature_code <= {15'd0, eff_rows}) &&
                   (req_chan.barcode_code <= {19'd0, eff_cols});

   // merge arithmetic on the entry just read
   assign addend   = use_counts_ff ?
                     csb_pkg::VAL_W'($signed(rd_data.cnt_key ^ 32'h8000_0000)) :
                     csb_pkg::VAL_W'(1);
   assign sum_next = sum_ff + addend;
   assign clamp    = list_format_ff && use_counts_ff &&
                     ((sum_next > SAT_HI) || (sum_next < SAT_LO));
   assign same     = ({1'b0, rd_data.col} == emit_col_ff) && (rd_data.row == row_ff);
   assign pos_inc  = pos_ff + csb_pkg::CNT_W'(1);
   assign rsp_load = (state_ff == T_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff    <= ROWS_CAP;
         num_cols_ff    <= COLS_CAP;
         use_counts_ff  <= 1'b1;
         list_format_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            csb_pkg::REG_NUM_ROWS:    num_rows_ff    <= csr_write_data;
            csb_pkg::REG_NUM_COLS:    num_cols_ff    <= csr_write_data[12:0];
            csb_pkg::REG_USE_COUNTS:  use_counts_ff  <= csr_write_data[0];
            csb_pkg::REG_LIST_FORMAT: list_format_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // main control
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      loaded_in    = loaded_ff;
      emit_col_in  = emit_col_ff;
      pos_in       = pos_ff;
      nnz_in       = nnz_ff;
      overrun_in   = overrun_ff;
      first_in     = first_ff;
      row_in       = row_ff;
      sum_in       = sum_ff;
      sat_in       = sat_ff;
      kind_in      = kind_ff;
      top_req      = '0;
      sort_ctl     = '0;
      sort_ctl.count = loaded_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               unique case (req_chan.action)
                  csb_pkg::ACT_ADD: begin
                     if (phase_ff == PH_LOAD && add_ok) begin
                        if (loaded_ff >= csb_pkg::CNT_W'(csb_pkg::MAX_ENTRIES)) begin
                           overrun_in = 1'b1;
                        end else begin
                           top_req.wr_en           = 1'b1;
                           top_req.wr_addr         = csb_pkg::ADDR_W'(loaded_ff);
                           top_req.wr_data.col     = 12'(req_chan.barcode_code - 32'd1);
                           top_req.wr_data.row     = 16'(req_chan.feature_code - 32'd1);
                           top_req.wr_data.cnt_key = req_chan.count ^ 32'h8000_0000;
                           loaded_in               = loaded_ff + csb_pkg::CNT_W'(1);
                        end
                     end
                  end
                  csb_pkg::ACT_FETCH: begin
                     if (phase_ff == PH_LOAD) begin
                        sort_ctl.start = 1'b1;
                        emit_col_in    = '0;
                        pos_in         = '0;
                        nnz_in         = '0;
                        phase_in       = PH_EMIT;
                        state_in       = T_SORT;
                     end else begin
                        state_in = T_EMIT;
                     end
                  end
                  csb_pkg::ACT_CLEAR: begin
                     loaded_in   = '0;
                     emit_col_in = '0;
                     pos_in      = '0;
                     nnz_in      = '0;
                     phase_in    = PH_LOAD;
                     overrun_in  = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         T_SORT: begin
            if (sort_stat.done) begin
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            sat_in = 1'b0;
            if (phase_ff != PH_EMIT || emit_col_ff >= eff_cols) begin
               phase_in = PH_DONE;
               kind_in  = csb_pkg::KIND_DONE;
               state_in = T_OUT;
            end else if (pos_ff >= loaded_ff) begin
               kind_in     = csb_pkg::KIND_COL_END;
               emit_col_in = emit_col_ff + 13'd1;
               state_in    = T_OUT;
            end else begin
               top_req.rd_en   = 1'b1;
               top_req.rd_addr = csb_pkg::ADDR_W'(pos_ff);
               first_in        = 1'b1;
               state_in        = T_DAT;
            end
         end
         T_DAT: begin
            if (first_ff) begin
               if ({1'b0, rd_data.col} != emit_col_ff) begin
                  kind_in     = csb_pkg::KIND_COL_END;
                  emit_col_in = emit_col_ff + 13'd1;
                  state_in    = T_OUT;
               end else begin
                  row_in   = rd_data.row;
                  sum_in   = addend;
                  first_in = 1'b0;
                  pos_in   = pos_inc;
                  if (pos_inc < loaded_ff) begin
                     top_req.rd_en   = 1'b1;
                     top_req.rd_addr = csb_pkg::ADDR_W'(pos_inc);
                  end else begin
                     kind_in  = csb_pkg::KIND_ENTRY;
                     nnz_in   = nnz_ff + csb_pkg::CNT_W'(1);
                     state_in = T_OUT;
                  end
               end
            end else if (same) begin
               // fold one duplicate, clamping in list format
               if (clamp) begin
                  sum_in = (sum_next > SAT_HI) ? SAT_HI : SAT_LO;
                  sat_in = 1'b1;
               end else begin
                  sum_in = sum_next;
               end
               pos_in = pos_inc;
               if (pos_inc < loaded_ff) begin
                  top_req.rd_en   = 1'b1;
                  top_req.rd_addr = csb_pkg::ADDR_W'(pos_inc);
               end else begin
                  kind_in  = csb_pkg::KIND_ENTRY;
                  nnz_in   = nnz_ff + csb_pkg::CNT_W'(1);
                  state_in = T_OUT;
               end
            end else begin
               kind_in  = csb_pkg::KIND_ENTRY;
               nnz_in   = nnz_ff + csb_pkg::CNT_W'(1);
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (rsp_load) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         phase_ff     <= PH_LOAD;
         loaded_ff    <= '0;
         emit_col_ff  <= '0;
         pos_ff       <= '0;
         nnz_ff       <= '0;
         overrun_ff   <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         loaded_ff    <= loaded_in;
         emit_col_ff  <= emit_col_in;
         pos_ff       <= pos_in;
         nnz_ff       <= nnz_in;
         overrun_ff   <= overrun_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      sum_ff  <= sum_in;
      sat_ff  <= sat_in;
      kind_ff <= kind_in;
   end

   // output register: hold until transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff <= kind_ff;
         rsp_col_ff  <= '0;
         rsp_row_ff  <= '0;
         rsp_val_ff  <= '0;
         rsp_ptr_ff  <= '0;
         rsp_ovf_ff  <= 1'b0;
         rsp_ovr_ff  <= overrun_ff;
         if (kind_ff == csb_pkg::KIND_ENTRY) begin
            rsp_col_ff <= emit_col_ff[11:0];
            rsp_row_ff <= row_ff;
            rsp_val_ff <= sum_ff;
            rsp_ovf_ff <= sat_ff;
         end else if (kind_ff == csb_pkg::KIND_COL_END) begin
            rsp_col_ff <= 12'(emit_col_ff - 13'd1);
            rsp_ptr_ff <= nnz_ff;
         end
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.result_kind        = rsp_kind_ff;
   assign rsp_chan.column_index       = rsp_col_ff;
   assign rsp_chan.row_index          = rsp_row_ff;
   assign rsp_chan.entry_value        = rsp_val_ff;
   assign rsp_chan.column_end_pointer = rsp_ptr_ff;
   assign rsp_chan.overflow           = rsp_ovf_ff;
   assign rsp_chan.store_overrun      = rsp_ovr_ff;

   // RAM port goes to the sorter while it runs
   assign ram_req = (state_ff == T_SORT) ? sort_req : top_req;

   csb_sorter u_sorter (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sort_ctl),
      .stat    (sort_stat),
      .ram_req (sort_req),
      .rd_data (rd_data)
   );

   csb_ram #(
      .ADDR_BITS (csb_pkg::ADDR_W),
      .DATA_BITS ($bits(csb_pkg::entry_type))
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= csb_pkg::CNT_W'(csb_pkg::MAX_ENTRIES))
      else $error("entry count beyond store depth");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_LOAD) |-> (pos_ff <= loaded_ff))
      else $error("emit position beyond loaded entries");
   assert property (@(posedge clock) disable iff (reset)
      sort_stat.done |-> (state_ff == T_SORT))
      else $error("sort finished outside sort wait");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_SORT) |-> !top_req.wr_en)
      else $error("store written by control during sort");
endmodule
